>>> sv/pkdb_pkg.sv
// Shared types and constants for the peak limiter with dB envelope.
package pkdb_pkg;

	// shared multiplier operand width
	localparam int MUL_W = 32;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd2;

	localparam int THR_W = 9;
	localparam int ENV_W = 16;
	localparam int COEF_W = 16;

	localparam logic             ENABLE_RST  = 1'b1;
	localparam logic [THR_W-1:0] THR_RST     = 9'h1E6;   // code -26 in Q8.8 (-26/256)
	localparam logic [COEF_W-1:0] COEF_RST   = 16'd65509;

	// 20*log10(2) in Q16.16, for the Q8.8 level
	localparam logic [MUL_W-1:0] DB_PER_LOG2    = 32'd394566;
	// ln(10)/20 per Q8.8 dB step, Q0.32
	localparam logic [MUL_W-1:0] NEPER_PER_DBQ8 = 32'd1931548;
	// ceil(2^33/3): floor(x/3) = (x * RECIP3) >> 33 for any 32-bit x
	localparam logic [MUL_W-1:0] RECIP3         = 32'hAAAA_AAAB;
	localparam logic [8:0]       GR_MAX         = 9'd256;

	typedef struct packed {
		logic             en;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_LVL_MUL,
		ST_LVL,
		ST_ENV_MUL,
		ST_ENV,
		ST_T_MUL,
		ST_T2_MUL,
		ST_T3_MUL,
		ST_T4_MUL,
		ST_D6_MUL,
		ST_D24_MUL,
		ST_GAIN,
		ST_OUT_MUL,
		ST_OUT
	} state_t;

endpackage

>>> sv/peak_limiter_db_envelope_top.sv
// Top level of the brickwall peak limiter with a shared dB-domain envelope.
// Limiting: tvalid rises after the input transaction and s_axis_tready returns with it, so one
// sample is in flight at a time, paced by the normalizer steps plus nine passes through the one
// shared 32x32 multiplier. Bypass (limiter_enable = 0): the sample goes straight to the output
// register, also one at a time. A stalled output holds the sequencer.
// Reset (arst_n low, async) empties the output, zeroes the envelope, restores register defaults.
module peak_limiter_db_envelope_top #(
	parameter int SAMPLE_BITS    = 24,
	parameter int LOG_TABLE_BITS = 10,
	localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pkdb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pkdb_pkg::CFG_DATA_W-1:0]   cfg_data,
	// sample input
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [DATA_W-1:0]                 s_axis_tdata,   // [SAMPLE_BITS-1:0] sample_in
	input  logic                              s_axis_tlast,   // block_last_in
	// sample output
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [DATA_W-1:0]                 m_axis_tdata,   // [SAMPLE_BITS-1:0] sample_out
	output logic                              m_axis_tlast    // block_last_out
);
	import pkdb_pkg::*;

	localparam int SH_W   = $clog2(SAMPLE_BITS);
	localparam int VMAG_W = SH_W + 16;
	localparam int PROD_W = 2 * MUL_W;

	// level offset: round(1e-6 full scale), at least one LSB
	localparam longint unsigned OFF_FULL =
		((64'd1 << (SAMPLE_BITS - 1)) + 64'd500000) / 64'd1000000;
	localparam logic [SAMPLE_BITS-1:0] OFFSET =
		(OFF_FULL == 0) ? SAMPLE_BITS'(1) : SAMPLE_BITS'(OFF_FULL);

	// ---------------------------------------------------------------
	// Configuration registers; writes take effect at once and are not held off by
	// the block, so the user must issue them only while no sample is in flight
	// ---------------------------------------------------------------
	logic              enable_q;
	logic [THR_W-1:0]  thr_q;
	logic [COEF_W-1:0] coef_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RST;
			thr_q    <= THR_RST;
			coef_q   <= COEF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE:    enable_q <= cfg_data[0];
				REG_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				REG_RELEASE:   coef_q   <= cfg_data[COEF_W-1:0];
				default: ;   // unmapped index, dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Input capture
	// ---------------------------------------------------------------
	state_t state_q, state_d;

	logic                   in_xfer;
	logic [SAMPLE_BITS-1:0] raw_in;
	logic                   neg_in;
	logic [SAMPLE_BITS-1:0] mag_in;

	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign raw_in  = s_axis_tdata[SAMPLE_BITS-1:0];
	assign neg_in  = raw_in[SAMPLE_BITS-1];
	// most negative code maps to 2^(SAMPLE_BITS-1) exactly in unsigned form
	assign mag_in  = neg_in ? (~raw_in + SAMPLE_BITS'(1)) : raw_in;

	// ---------------------------------------------------------------
	// Normalizer, log table, shared multiplier
	// ---------------------------------------------------------------
	logic                      norm_start;
	logic                      norm_done;
	logic [LOG_TABLE_BITS-1:0] norm_k;
	logic [SH_W-1:0]           norm_sh;
	logic [15:0]               tab_q;
	mul_req_t                  mul_req;
	logic [PROD_W-1:0]         prod_q;

	pkdb_norm #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.m_in   (mag_in + OFFSET),
		.done_q (norm_done),
		.k      (norm_k),
		.sh_q   (norm_sh)
	);

	// read every cycle; the entry for the final k is ready the cycle after norm_done
	pkdb_log_rom #(
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_rom (
		.clk    (clk),
		.addr   (norm_k),
		.data_q (tab_q)
	);

	pkdb_mul u_mul (
		.clk    (clk),
		.req    (mul_req),
		.prod_q (prod_q)
	);

	// ---------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic                   neg_q;
	logic                   last_q;
	logic                   bypass_q;
	logic signed [ENV_W-1:0] lvl_q;
	logic signed [ENV_W-1:0] env_q;
	logic [28:0]            t_q;      // t  < 2^29, Q0.32
	logic [25:0]            t2_q;
	logic [22:0]            t3_q;
	logic [19:0]            t4_q;
	logic [20:0]            t3d6_q;
	logic [16:0]            gain_q;   // Q1.16, at most 1.0
	logic                   out_valid_q;
	logic [DATA_W-1:0]      out_data_q;
	logic                   out_last_q;

	// log2 magnitude: v = T[k] - sh*2^16, negative whenever sh is nonzero
	logic              neg_v;
	logic [VMAG_W-1:0] vmag;
	assign neg_v = norm_sh != '0;
	assign vmag  = neg_v ? ({norm_sh, 16'h0000} - VMAG_W'(tab_q)) : VMAG_W'(tab_q);

	// level in Q8.8, rounded half away from zero
	logic [PROD_W-1:0] lvl_sum;
	logic [ENV_W-1:0]  lvl_mag;
	assign lvl_sum = prod_q + PROD_W'(64'h0080_0000);
	assign lvl_mag = lvl_sum[24 +: ENV_W];

	// release: env - lvl is nonnegative whenever the envelope falls
	logic [ENV_W:0] env_diff;
	logic           rise;
	logic [ENV_W-1:0] env_rel;
	assign env_diff = {env_q[ENV_W-1], env_q} - {lvl_q[ENV_W-1], lvl_q};
	assign rise     = lvl_q > env_q;
	assign env_rel  = lvl_q + prod_q[16 +: ENV_W];

	// gain reduction in Q8.8; a positive threshold acts as 0 dB
	logic [THR_W-1:0]  thr_eff;
	logic signed [17:0] gr_diff;
	logic [8:0]        gr;
	assign thr_eff = thr_q[THR_W-1] ? thr_q : '0;
	assign gr_diff = {{2{env_q[ENV_W-1]}}, env_q} - {{(18-THR_W){thr_eff[THR_W-1]}}, thr_eff};

	always_comb begin
		if (gr_diff <= 18'sd0) begin
			gr = '0;
		end else if (gr_diff > 18'sd256) begin
			gr = GR_MAX;
		end else begin
			gr = gr_diff[8:0];
		end
	end

	// fourth-order series of exp(-t), then round to Q1.16
	logic [15:0] t4d24;
	logic [33:0] e_sum;
	logic [33:0] e_rnd;
	assign t4d24 = prod_q[48:33];
	assign e_sum = 34'h1_0000_0000 - 34'(t_q) + 34'(t2_q[25:1]) - 34'(t3d6_q) + 34'(t4d24);
	assign e_rnd = e_sum + 34'h0_0000_8000;

	// output scaling, rounded half up in magnitude
	logic [PROD_W-1:0]      y_sum;
	logic [SAMPLE_BITS-1:0] y_mag;
	logic [SAMPLE_BITS-1:0] y_out;
	logic                   out_load;
	assign y_sum    = prod_q + PROD_W'(64'h8000);
	assign y_mag    = y_sum[16 +: SAMPLE_BITS];
	assign y_out    = bypass_q ? sample_q
	                : (neg_q ? (~y_mag + SAMPLE_BITS'(1)) : y_mag);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= raw_in;
			mag_q    <= mag_in;
			neg_q    <= neg_in;
			last_q   <= s_axis_tlast;
			bypass_q <= !enable_q;
		end
		case (state_q)
			ST_LVL:     lvl_q  <= neg_v ? -lvl_mag : lvl_mag;
			ST_T2_MUL:  t_q    <= prod_q[28:0];
			ST_T3_MUL:  t2_q   <= prod_q[57:32];
			ST_T4_MUL:  t3_q   <= prod_q[54:32];
			ST_D6_MUL:  t4_q   <= prod_q[51:32];
			ST_D24_MUL: t3d6_q <= prod_q[53:33];
			ST_GAIN:    gain_q <= e_rnd[32:16];
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= DATA_W'(y_out);
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ENV) begin
				env_q <= rise ? lvl_q : env_rel;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_xfer) state_d = enable_q ? ST_NORM : ST_OUT;
			ST_NORM:    if (norm_done) state_d = ST_LVL_MUL;
			ST_LVL_MUL: state_d = ST_LVL;
			ST_LVL:     state_d = ST_ENV_MUL;
			ST_ENV_MUL: state_d = ST_ENV;
			ST_ENV:     state_d = ST_T_MUL;
			ST_T_MUL:   state_d = ST_T2_MUL;
			ST_T2_MUL:  state_d = ST_T3_MUL;
			ST_T3_MUL:  state_d = ST_T4_MUL;
			ST_T4_MUL:  state_d = ST_D6_MUL;
			ST_D6_MUL:  state_d = ST_D24_MUL;
			ST_D24_MUL: state_d = ST_GAIN;
			ST_GAIN:    state_d = ST_OUT_MUL;
			ST_OUT_MUL: state_d = ST_OUT;
			ST_OUT:     if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer: outputs (handshake, normalizer start, multiplier operands)
	// ---------------------------------------------------------------
	always_comb begin
		s_axis_tready = 1'b0;
		norm_start    = 1'b0;
		mul_req       = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				norm_start    = s_axis_tvalid && enable_q;
			end
			ST_LVL_MUL: begin
				mul_req = '{en: 1'b1, a: MUL_W'(vmag), b: DB_PER_LOG2};
			end
			ST_ENV_MUL: begin
				mul_req = '{en: 1'b1, a: MUL_W'(coef_q), b: MUL_W'(env_diff)};
			end
			ST_T_MUL: begin
				mul_req = '{en: 1'b1, a: MUL_W'(gr), b: NEPER_PER_DBQ8};
			end
			ST_T2_MUL: begin
				mul_req = '{en: 1'b1, a: prod_q[MUL_W-1:0], b: prod_q[MUL_W-1:0]};
			end
			ST_T3_MUL: begin
				mul_req = '{en: 1'b1, a: MUL_W'(prod_q[57:32]), b: MUL_W'(t_q)};
			end
			ST_T4_MUL: begin
				mul_req = '{en: 1'b1, a: MUL_W'(prod_q[54:32]), b: MUL_W'(t_q)};
			end
			ST_D6_MUL: begin
				// t3/6 as (t3/2)/3
				mul_req = '{en: 1'b1, a: MUL_W'(t3_q[22:1]), b: RECIP3};
			end
			ST_D24_MUL: begin
				// t4/24 as (t4/8)/3
				mul_req = '{en: 1'b1, a: MUL_W'(t4_q[19:3]), b: RECIP3};
			end
			ST_OUT_MUL: begin
				mul_req = '{en: 1'b1, a: MUL_W'(mag_q), b: MUL_W'(gain_q)};
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> sv/pkdb_mul.sv
// Shared unsigned multiplier with registered product.
module pkdb_mul (
	input  logic                            clk,
	input  pkdb_pkg::mul_req_t              req,
	output logic [2*pkdb_pkg::MUL_W-1:0]    prod_q
);
	import pkdb_pkg::*;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= (2*MUL_W)'(req.a) * (2*MUL_W)'(req.b);
		end
	end

endmodule

>>> sv/pkdb_log_rom.sv
// Registered ROM of log2(1 + k/2^LOG_TABLE_BITS) in Q0.16.
module pkdb_log_rom #(
	parameter int LOG_TABLE_BITS = 10
) (
	input  logic                      clk,
	input  logic [LOG_TABLE_BITS-1:0] addr,
	output logic [15:0]               data_q
);
	localparam int LOG_SIZE = 1 << LOG_TABLE_BITS;

	typedef logic [15:0] log_tab_t [LOG_SIZE];

	// bitwise log2 by repeated squaring in Q1.30, truncating
	function automatic log_tab_t build_tab();
		log_tab_t        tab;
		longint unsigned x;
		logic [15:0]     r;
		for (int k = 0; k < LOG_SIZE; k++) begin
			x = (longint'(LOG_SIZE) + longint'(k)) << (30 - LOG_TABLE_BITS);
			r = '0;
			for (int i = 0; i < 16; i++) begin
				x = (x * x) >> 30;
				r = r << 1;
				if (x >= (64'd2 << 30)) begin
					x = x >> 1;
					r[0] = 1'b1;
				end
			end
			tab[k] = r;
		end
		return tab;
	endfunction

	localparam log_tab_t LOG_TAB = build_tab();

	always_ff @(posedge clk) begin
		data_q <= LOG_TAB[addr];
	end

endmodule

>>> sv/pkdb_norm.sv
// Iterative leading-one normalizer: binary-step left shifts, one step per cycle.
module pkdb_norm #(
	parameter int SAMPLE_BITS    = 24,
	parameter int LOG_TABLE_BITS = 10,
	localparam int SH_W          = $clog2(SAMPLE_BITS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [SAMPLE_BITS-1:0]    m_in,
	output logic                      done_q,
	output logic [LOG_TABLE_BITS-1:0] k,
	output logic [SH_W-1:0]           sh_q
);
	localparam logic [SH_W-1:0] TOP_AMT = SH_W'(1) << (SH_W - 1);

	logic [SAMPLE_BITS-1:0] m_q;
	logic [SH_W-1:0]        amt_q;
	logic                   busy_q;
	logic [SAMPLE_BITS-1:0] top_mask;
	logic                   hi_zero;

	assign top_mask = ~({SAMPLE_BITS{1'b1}} >> amt_q);
	assign hi_zero  = (m_q & top_mask) == '0;
	// mantissa bits just below the leading one
	assign k        = m_q[SAMPLE_BITS-2 -: LOG_TABLE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			amt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			amt_q  <= TOP_AMT;
		end else if (busy_q) begin
			amt_q <= amt_q >> 1;
			if (amt_q == SH_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q  <= m_in;
			sh_q <= '0;
		end else if (busy_q && hi_zero) begin
			m_q  <= m_q << amt_q;
			sh_q <= sh_q + amt_q;
		end
	end

endmodule

>>> sv/pkdb_checker.sv
// Port-level checks for the peak limiter, bound to the top level.
module pkdb_checker #(
	parameter int DATA_W = 24
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata,
	input logic              m_axis_tlast
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output transaction changed while stalled");

	// one sample in flight: input closes right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted a second sample while busy");

	// a new result appears exactly when the sequencer returns to idle
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready && !$past(s_axis_tready))
		else $error("result not tied to end of processing");

endmodule

bind peak_limiter_db_envelope_top pkdb_checker #(
	.DATA_W (DATA_W)
) u_pkdb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
